### sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_ON(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/dxt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dxt_pkg;

  // Stream and register port widths
  localparam int unsigned InW   = 152;
  localparam int unsigned OutW  = 64;
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  // Live configuration handed to the datapath
  typedef struct packed {
    logic        dxt5;
    logic [14:0] width;
    logic [14:0] height;
  } cfg_t;

  // First stage: widened endpoints and interpolation numerators
  typedef struct packed {
    logic [2:0][7:0]  e0;
    logic [2:0][7:0]  e1;
    logic [2:0][9:0]  num_a;   // 2*e0 + e1
    logic [2:0][9:0]  num_b;   // e0 + 2*e1
    logic [2:0][8:0]  sum;     // e0 + e1
    logic [5:0][10:0] anum;    // alpha numerators for entries 2..7
    logic             a_gt;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic             dxt5;
    logic             punch;
    logic [31:0]      cidx;
    logic [47:0]      aidx;
    logic [15:0]      mask;
    logic [11:0]      bx;
    logic [11:0]      by;
  } s1_t;

  // Second stage: finished palette and alpha table
  typedef struct packed {
    logic [3:0][2:0][7:0] pal;
    logic [7:0][7:0]      atab;
    logic                 dxt5;
    logic                 punch;
    logic [31:0]          cidx;
    logic [47:0]          aidx;
    logic [15:0]          mask;
    logic [11:0]          bx;
    logic [11:0]          by;
  } s2_t;

  // Widen RGB565 to three 8-bit channels, index 0 red
  function automatic logic [2:0][7:0] widen565(input logic [15:0] c);
    logic [2:0][7:0] res;
    res[0] = {c[15:11], c[15:13]};
    res[1] = {c[10:5], c[10:9]};
    res[2] = {c[4:0], c[4:2]};
    return res;
  endfunction

  // Floor divide by 3 for n <= 767
  function automatic logic [7:0] div3(input logic [9:0] n);
    logic [19:0] p;
    p = 20'(n) * 20'd683;
    return p[18:11];
  endfunction

  // Floor divide by 5 for n <= 1279
  function automatic logic [7:0] div5(input logic [10:0] n);
    logic [20:0] p;
    p = 21'(n) * 21'd1639;
    return p[20:13];
  endfunction

  // Floor divide by 7 for n <= 1791
  function automatic logic [7:0] div7(input logic [10:0] n);
    logic [21:0] p;
    p = 22'(n) * 22'd2341;
    return p[21:14];
  endfunction

endpackage
`default_nettype wire

### sv/dxt_block_decompress.sv
// DXT1 / DXT5 block decompressor.
// Input stream: one 4x4 compressed block per item. tdata carries the colour
// half, the alpha half, the block column and the block row. Output stream:
// one decoded pixel per item with its image position; tlast marks the final
// pixel of a block. Pixels outside the image are dropped, so a block gives
// 0 to 16 items; a block wholly outside the image gives none.
// An APB port holds texture_format (0x0), image_width (0x4) and
// image_height (0x8); write them only while the block is idle.
// The first pixel of a block passes, in order, the first palette stage (loaded
// at the edge that accepts the block), the second stage, the block holder
// and the output register before it shows on m_axis.
// Throughput: the block holder emits one pixel per cycle while m_axis_tready
// lets the output register drain; the two palette stages take a new block
// every cycle while they have room, so blocks queue behind the one being
// emitted.
// Reset clears all valid flags and sets format 0 and size 1x1.
// When m_axis_tready is low the output register holds its item and the
// stages fill up and then lower s_axis_tready; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module dxt_block_decompress import dxt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // color_block[63:0], alpha_block[127:64], block_col[139:128],
  // block_row[151:140]
  input  wire logic [InW-1:0]   s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // pixel_x[13:0], pixel_y[27:14], red[35:28], green[43:36], blue[51:44],
  // alpha[59:52], zero[63:60]
  output logic      [OutW-1:0]  m_axis_tdata,
  output logic                  m_axis_tlast,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  cfg_t cfg;
  logic pal_valid;
  logic pal_ready;
  s2_t  pal_data;

  // Configuration registers
  dxt_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // Palette and alpha table pipeline
  dxt_palette u_palette (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (pal_valid),
    .out_ready_i (pal_ready),
    .out_data_o  (pal_data)
  );

  // Per-pixel emission
  dxt_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pal_valid),
    .in_ready_o  (pal_ready),
    .in_data_i   (pal_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
`default_nettype wire

### sv/dxt_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module dxt_cfg import dxt_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel_i,
  input  wire logic             penable_i,
  input  wire logic             pwrite_i,
  input  wire logic [AddrW-1:0] paddr_i,
  input  wire logic [DataW-1:0] pwdata_i,
  output logic      [DataW-1:0] prdata_o,
  output logic                  pready_o,
  output cfg_t                  cfg_o
);

  logic        fmt_q;
  logic [14:0] width_q;
  logic [14:0] height_q;
  logic        wr_en;
  reg_idx_e    idx;

  assign idx      = reg_idx_e'(paddr_i[3:2]);
  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;

  // Write registers in the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= 1'b0;
      width_q  <= 15'd1;
      height_q <= 15'd1;
    end else if (wr_en) begin
      unique case (idx)
        REG_FORMAT: fmt_q    <= pwdata_i[0];
        REG_WIDTH:  width_q  <= pwdata_i[14:0];
        REG_HEIGHT: height_q <= pwdata_i[14:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      REG_FORMAT: prdata_o = {31'd0, fmt_q};
      REG_WIDTH:  prdata_o = {17'd0, width_q};
      REG_HEIGHT: prdata_o = {17'd0, height_q};
      default:    prdata_o = '0;
    endcase
  end

  assign cfg_o.dxt5   = fmt_q;
  assign cfg_o.width  = width_q;
  assign cfg_o.height = height_q;

endmodule
`default_nettype wire

### sv/dxt_palette.sv
`timescale 1ns / 1ps
`default_nettype none
module dxt_palette import dxt_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cfg_t           cfg_i,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [InW-1:0] in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output s2_t                 out_data_o
);

  logic        s1_valid_q;
  s1_t         s1_q;
  s1_t         s1_d;
  logic        s2_valid_q;
  s2_t         s2_q;
  s2_t         s2_d;
  logic        s1_en;
  logic        s2_en;
  logic [15:0] c0;
  logic [15:0] c1;
  logic [3:0]  colv;
  logic [3:0]  rowv;

  assign c0 = in_data_i[15:0];
  assign c1 = in_data_i[31:16];

  // Stage one: unpack, widen, clip mask, numerators
  always_comb begin
    s1_d.e0    = widen565(c0);
    s1_d.e1    = widen565(c1);
    s1_d.cidx  = in_data_i[63:32];
    s1_d.a0    = in_data_i[71:64];
    s1_d.a1    = in_data_i[79:72];
    s1_d.aidx  = in_data_i[127:80];
    s1_d.bx    = in_data_i[139:128];
    s1_d.by    = in_data_i[151:140];
    s1_d.dxt5  = cfg_i.dxt5;
    s1_d.punch = !cfg_i.dxt5 && (c0 <= c1);
    s1_d.a_gt  = s1_d.a0 > s1_d.a1;
    for (int ch = 0; ch < 3; ch++) begin
      s1_d.num_a[ch] = {1'b0, s1_d.e0[ch], 1'b0} + {2'b00, s1_d.e1[ch]};
      s1_d.num_b[ch] = {2'b00, s1_d.e0[ch]} + {1'b0, s1_d.e1[ch], 1'b0};
      s1_d.sum[ch]   = {1'b0, s1_d.e0[ch]} + {1'b0, s1_d.e1[ch]};
    end
    for (int k = 0; k < 6; k++) begin
      if (s1_d.a_gt) begin
        s1_d.anum[k] = 11'(6 - k) * 11'(s1_d.a0) + 11'(k + 1) * 11'(s1_d.a1);
      end else if (k < 4) begin
        s1_d.anum[k] = 11'(4 - k) * 11'(s1_d.a0) + 11'(k + 1) * 11'(s1_d.a1);
      end else begin
        s1_d.anum[k] = '0;
      end
    end
    for (int c = 0; c < 4; c++) begin
      colv[c] = {1'b0, s1_d.bx, 2'(c)} < cfg_i.width;
      rowv[c] = {1'b0, s1_d.by, 2'(c)} < cfg_i.height;
    end
    for (int p = 0; p < 16; p++) begin
      s1_d.mask[p] = colv[p & 3] & rowv[p >> 2];
    end
  end

  // Stage two: divide by constants, build palette and alpha table
  always_comb begin
    s2_d.dxt5  = s1_q.dxt5;
    s2_d.punch = s1_q.punch;
    s2_d.cidx  = s1_q.cidx;
    s2_d.aidx  = s1_q.aidx;
    s2_d.mask  = s1_q.mask;
    s2_d.bx    = s1_q.bx;
    s2_d.by    = s1_q.by;
    s2_d.pal[0] = s1_q.e0;
    s2_d.pal[1] = s1_q.e1;
    for (int ch = 0; ch < 3; ch++) begin
      s2_d.pal[2][ch] = s1_q.punch ? s1_q.sum[ch][8:1] : div3(s1_q.num_a[ch]);
      s2_d.pal[3][ch] = s1_q.punch ? 8'd0 : div3(s1_q.num_b[ch]);
    end
    s2_d.atab[0] = s1_q.a0;
    s2_d.atab[1] = s1_q.a1;
    for (int k = 0; k < 6; k++) begin
      if (s1_q.a_gt) begin
        s2_d.atab[k + 2] = div7(s1_q.anum[k]);
      end else if (k < 4) begin
        s2_d.atab[k + 2] = div5(s1_q.anum[k]);
      end else if (k == 4) begin
        s2_d.atab[k + 2] = 8'd0;
      end else begin
        s2_d.atab[k + 2] = 8'd255;
      end
    end
  end

  // Advance a stage when its slot is empty or drains
  assign s2_en      = !s2_valid_q || out_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) s1_q <= s1_d;
    if (s2_en && s1_valid_q) s2_q <= s2_d;
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

endmodule
`default_nettype wire

### sv/dxt_serial.sv
`timescale 1ns / 1ps
`default_nettype none
module dxt_serial import dxt_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire s2_t             in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic      [OutW-1:0] out_data_o,
  output logic                 out_last_o
);

  s2_t             blk_q;
  logic [15:0]     mask_q;
  logic [15:0]     mask_d;
  logic            out_valid_q;
  logic [OutW-1:0] out_data_q;
  logic [OutW-1:0] out_data_d;
  logic            out_last_q;
  logic [15:0]     low;
  logic [3:0]      idx;
  logic [1:0]      ci;
  logic [2:0]      ai;
  logic [5:0]      abase;
  logic [2:0][7:0] rgb;
  logic [7:0]      alpha;
  logic            last;
  logic            has_px;
  logic            out_free;
  logic            emit;
  logic            load;

  // Pick the lowest pending pixel of the block
  always_comb begin
    low = mask_q & (~mask_q + 16'd1);
    idx = '0;
    for (int p = 0; p < 16; p++) begin
      if (low[p]) idx = idx | 4'(p);
    end
  end

  assign last  = (mask_q & ~low) == 16'd0;
  assign abase = 6'(idx) * 6'd3;
  assign ci    = blk_q.cidx[{idx, 1'b0} +: 2];
  assign ai    = blk_q.aidx[abase +: 3];
  assign rgb   = blk_q.pal[ci];

  // Alpha from the table in DXT5, else opaque except transparent black
  always_comb begin
    if (blk_q.dxt5) begin
      alpha = blk_q.atab[ai];
    end else if (blk_q.punch && (ci == 2'd3)) begin
      alpha = 8'd0;
    end else begin
      alpha = 8'd255;
    end
  end

  assign out_data_d = {4'd0, alpha, rgb[2], rgb[1], rgb[0],
                       blk_q.by, idx[3:2], blk_q.bx, idx[1:0]};

  // Handshake between block holder and output register
  assign has_px     = |mask_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = has_px && out_free;
  assign in_ready_o = !has_px || (emit && last);
  assign load       = in_valid_i && in_ready_o;

  // Drop emitted pixels, take a new block when the current one is done
  always_comb begin
    mask_d = mask_q;
    if (load) begin
      mask_d = in_data_i.mask;
    end else if (emit) begin
      mask_d = mask_q & ~low;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (out_free) out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) blk_q <= in_data_i;
    if (emit) begin
      out_data_q <= out_data_d;
      out_last_q <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

### sv/dxt_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dxt_chk import dxt_pkg::*; (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            m_axis_tvalid,
  input wire logic            m_axis_tready,
  input wire logic [OutW-1:0] m_axis_tdata,
  input wire logic            m_axis_tlast
);

  // A stalled output item holds
  `ASSERT_ON(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed while stalled")

  // No output item once reset has been seen at an edge
  `ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |=> !m_axis_tvalid, "output valid during reset")

  // After a pixel that is not last, the next pixel of the same block follows
  `ASSERT_ON(a_block_run, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tdata[13:2] == $past(m_axis_tdata[13:2]) && m_axis_tdata[27:16] == $past(m_axis_tdata[27:16]), "block run broken before last pixel")

endmodule

bind dxt_block_decompress dxt_chk u_chk (.*);
`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import dxt_pkg::*;

  localparam int unsigned MaxDim       = 16384;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned HoldCycles   = 120;
  localparam int unsigned NumDirected  = 20;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned PhaseItems   = 17;
  // Index past the last register; writes to it must be ignored
  localparam logic [1:0]  REG_UNUSED   = 2'd3;

  // Input item, laid out so that it maps straight onto s_axis_tdata
  typedef struct packed {
    logic [11:0] row;
    logic [11:0] col;
    logic [63:0] alpha;
    logic [63:0] color;
  } block_t;

  // One decoded pixel
  typedef struct packed {
    logic [13:0] px_x;
    logic [13:0] px_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last_px;
  } pixel_t;

  // Directed row: settings, block, and a hand-written pixel where obvious
  typedef struct packed {
    logic        fmt;
    logic [14:0] w;
    logic [14:0] h;
    logic [63:0] color;
    logic [63:0] alpha;
    logic [11:0] col;
    logic [11:0] row;
    logic        typed;
    logic        typed_n;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
  } vec_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // color_block[63:0], alpha_block[127:64], block_col[139:128], block_row[151:140]
  logic [InW-1:0]   s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // pixel_x[13:0], pixel_y[27:14], red[35:28], green[43:36], blue[51:44],
  // alpha[59:52], zero[63:60]
  logic [OutW-1:0]  m_axis_tdata;
  logic             m_axis_tlast;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Register shadow, reset values
  logic             cur_dxt5 = 1'b0;
  logic [14:0]      cur_width = 15'd1;
  logic [14:0]      cur_height = 15'd1;

  pixel_t           pixel_q [$];
  int unsigned      fail_cnt = 0;
  int unsigned      cycle_cnt = 0;
  bit               hold_req = 1'b0;
  logic             use_typed = 1'b0;
  logic             typed_n = 1'b0;
  pixel_t           typed_px = '0;

  dxt_block_decompress u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("[dxt_block_decompress] ERROR");
      $finish;
    end
  end

  // Decode one block under the current settings and queue its visible pixels
  function automatic void predict_pixels(input block_t b);
    logic [7:0]  e0 [3];
    logic [7:0]  e1 [3];
    logic [7:0]  pal [4][4];
    logic [7:0]  atab [8];
    logic [15:0] c0, c1;
    logic [7:0]  a0, a1;
    logic [1:0]  ci;
    int unsigned w, h, x, y;
    int          ch, i, p;
    pixel_t      held;
    bit          have;
    c0 = b.color[15:0];
    c1 = b.color[31:16];
    e0[0] = {c0[15:11], c0[15:13]};
    e0[1] = {c0[10:5], c0[10:9]};
    e0[2] = {c0[4:0], c0[4:2]};
    e1[0] = {c1[15:11], c1[15:13]};
    e1[1] = {c1[10:5], c1[10:9]};
    e1[2] = {c1[4:0], c1[4:2]};
    // Build the colour palette
    for (ch = 0; ch < 3; ch++) begin
      pal[0][ch] = e0[ch];
      pal[1][ch] = e1[ch];
    end
    for (i = 0; i < 4; i++) pal[i][3] = 8'd255;
    if (cur_dxt5 || c0 > c1) begin
      for (ch = 0; ch < 3; ch++) begin
        pal[2][ch] = 8'((2 * e0[ch] + e1[ch]) / 3);
        pal[3][ch] = 8'((2 * e1[ch] + e0[ch]) / 3);
      end
    end else begin
      // Three colours plus transparent black
      for (ch = 0; ch < 3; ch++) begin
        pal[2][ch] = 8'((e0[ch] + e1[ch]) / 2);
        pal[3][ch] = 8'd0;
      end
      pal[3][3] = 8'd0;
    end
    // Build the alpha table
    a0 = b.alpha[7:0];
    a1 = b.alpha[15:8];
    atab[0] = a0;
    atab[1] = a1;
    if (a0 > a1) begin
      for (i = 1; i <= 6; i++) atab[i + 1] = 8'(((7 - i) * a0 + i * a1) / 7);
    end else begin
      for (i = 1; i <= 4; i++) atab[i + 1] = 8'(((5 - i) * a0 + i * a1) / 5);
      atab[6] = 8'd0;
      atab[7] = 8'd255;
    end
    // Walk the block in raster order, drop clipped pixels
    w = (cur_width > MaxDim) ? MaxDim : cur_width;
    h = (cur_height > MaxDim) ? MaxDim : cur_height;
    have = 1'b0;
    held = '0;
    for (p = 0; p < 16; p++) begin
      x = b.col * 4 + p % 4;
      y = b.row * 4 + p / 4;
      if (x < w && y < h) begin
        if (have) pixel_q.push_back(held);
        ci = b.color[32 + 2 * p +: 2];
        held.px_x = 14'(x);
        held.px_y = 14'(y);
        held.red = pal[ci][0];
        held.green = pal[ci][1];
        held.blue = pal[ci][2];
        held.alpha = cur_dxt5 ? atab[b.alpha[16 + 3 * p +: 3]] : pal[ci][3];
        held.last_px = 1'b0;
        have = 1'b1;
      end
    end
    if (have) begin
      held.last_px = 1'b1;
      pixel_q.push_back(held);
    end
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  // Record expectations on input items, check output items
  always @(posedge clk_i) begin
    pixel_t want, got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (!use_typed) predict_pixels(block_t'(s_axis_tdata));
        else if (typed_n) pixel_q.push_back(typed_px);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{px_x: m_axis_tdata[13:0], px_y: m_axis_tdata[27:14],
                red: m_axis_tdata[35:28], green: m_axis_tdata[43:36],
                blue: m_axis_tdata[51:44], alpha: m_axis_tdata[59:52],
                last_px: m_axis_tlast};
        if (pixel_q.size() == 0) begin
          $error("pixel at x %0d y %0d with no pixel expected", got.px_x, got.px_y);
          fail_cnt++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_x", want.px_x, got.px_x);
          check_field("pixel_y", want.px_y, got.px_y);
          check_field("red", want.red, got.red);
          check_field("green", want.green, got.green);
          check_field("blue", want.blue, got.blue);
          check_field("alpha", want.alpha, got.alpha);
          check_field("last_pixel", want.last_px, got.last_px);
        end
      end
    end
  end

  // Receiver: stall in changing patterns, hold off long on request
  initial begin
    int unsigned mode, span, tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 4);
      span = $urandom_range(8, 64);
      repeat (span) begin
        @(negedge clk_i);
        tick++;
        if (hold_req) begin
          hold_req = 1'b0;
          m_axis_tready <= 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
        end
        case (mode)
          0, 1:    m_axis_tready <= 1'b1;
          2:       m_axis_tready <= 1'($urandom_range(0, 1));
          3:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= (tick % 4 == 0);
        endcase
      end
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_FORMAT: cur_dxt5 = val[0];
      REG_WIDTH:  cur_width = val[14:0];
      REG_HEIGHT: cur_height = val[14:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic expect_reg(input logic [1:0] idx, input string name,
                            input logic [31:0] want, input logic [31:0] mask);
    logic [31:0] rd;
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if ((rd & mask) !== want) begin
      $error("%s readback: expected %0d, got %0d", name, want, rd & mask);
      fail_cnt++;
    end
  endtask

  task automatic check_regs();
    expect_reg(REG_FORMAT, "texture_format", {31'd0, cur_dxt5}, 32'h1);
    expect_reg(REG_WIDTH, "image_width", {17'd0, cur_width}, 32'h7FFF);
    expect_reg(REG_HEIGHT, "image_height", {17'd0, cur_height}, 32'h7FFF);
  endtask

  // Drop valid and wait until every queued pixel has come out
  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk_i);
  endtask

  // Reprogram while idle; upper data bits carry junk the block must mask
  task automatic set_config(input logic dxt5, input int unsigned w, input int unsigned h);
    logic [31:0] junk;
    wait_drain();
    repeat (SettleCycles) @(negedge clk_i);
    junk = $urandom;
    reg_write(REG_FORMAT, {junk[31:1], dxt5});
    junk = $urandom;
    reg_write(REG_WIDTH, {junk[31:15], 15'(w)});
    junk = $urandom;
    reg_write(REG_HEIGHT, {junk[31:15], 15'(h)});
    check_regs();
  endtask

  // Offer one block and hold it until accepted; valid stays high afterwards
  task automatic send_block(input block_t b, input logic typed, input logic tn,
                            input pixel_t tpx);
    @(negedge clk_i);
    s_axis_tdata <= b;
    s_axis_tvalid <= 1'b1;
    use_typed = typed;
    typed_n = tn;
    typed_px = tpx;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    vec_t        directed_vecs [NumDirected];
    vec_t        v;
    block_t      blk;
    pixel_t      tpx;
    int unsigned k, ph, i, burst_left, gap, wlim, hlim;

    directed_vecs = '{
      // Reset settings: 1x1 DXT1 image
      '{0, 1, 1, 64'h0, 64'h0, 0, 0, 1, 1, 0, 0, 0, 255},
      '{0, 1, 1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0,
        1, 1, 0, 0, 0, 0},
      '{0, 1, 1, 64'h0000_0000_0000_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0,
        1, 1, 255, 255, 255, 255},
      '{0, 1, 1, 64'h1234_5678_9ABC_DEF0, 64'h0, 1, 0, 1, 0, 0, 0, 0, 0},
      '{0, 1, 1, 64'h1234_5678_9ABC_DEF0, 64'h0, 4095, 4095, 1, 0, 0, 0, 0, 0},
      // Largest image, DXT1 four-colour and punch-through
      '{0, 16384, 16384, 64'hE4E4_E4E4_001F_F800, 64'h0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 16384, 16384, 64'h1B1B_1B1B_F800_001F, 64'h0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 16384, 16384, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4095, 4095,
        0, 0, 0, 0, 0, 0},
      '{0, 16384, 16384, 64'h8D2C_61F0_7BEF_A514, 64'h0, 4095, 0, 0, 0, 0, 0, 0, 0},
      // Clipping on a 6x7 image: partly clipped, unclipped and fully clipped blocks
      '{0, 6, 7, 64'h39C6_E4B1_0841_F7DE, 64'h0, 1, 1, 0, 0, 0, 0, 0, 0},
      '{0, 6, 7, 64'h39C6_E4B1_0841_F7DE, 64'h0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 6, 7, 64'h39C6_E4B1_0841_F7DE, 64'h0, 2, 0, 1, 0, 0, 0, 0, 0},
      // DXT5: eight-entry alpha, six-entry alpha, equal endpoints
      '{1, 16384, 16384, 64'hE4E4_E4E4_07E0_F81F, 64'hFAC6_88FA_C688_00FF, 0, 0,
        0, 0, 0, 0, 0, 0},
      '{1, 16384, 16384, 64'hE4E4_E4E4_07E0_F81F, 64'hFAC6_88FA_C688_FF00, 0, 0,
        0, 0, 0, 0, 0, 0},
      '{1, 16384, 16384, 64'hE4E4_E4E4_07E0_F81F, 64'hFAC6_88FA_C688_8080, 0, 0,
        0, 0, 0, 0, 0, 0},
      '{1, 16384, 16384, 64'h5555_AAAA_FFFF_0000, 64'hFAC6_88FA_C688_37C8, 3, 5,
        0, 0, 0, 0, 0, 0},
      '{1, 16384, 16384, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4095, 4095,
        0, 0, 0, 0, 0, 0},
      // Oversized dimensions clamp to the maximum
      '{1, 32767, 32767, 64'h9C3A_5E71_C3B2_2D4F, 64'h053A_C1F7_9E20_64B3, 4095, 4095,
        0, 0, 0, 0, 0, 0},
      // Zero width, then zero height
      '{1, 0, 5, 64'h9C3A_5E71_C3B2_2D4F, 64'h053A_C1F7_9E20_64B3, 0, 0,
        1, 0, 0, 0, 0, 0},
      '{0, 5, 0, 64'h9C3A_5E71_C3B2_2D4F, 64'h053A_C1F7_9E20_64B3, 0, 0,
        1, 0, 0, 0, 0, 0}
    };

    // Hold reset at the start, then release it
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    check_regs();

    // Directed rows, reprogramming only where the settings change
    for (k = 0; k < NumDirected; k++) begin
      v = directed_vecs[k];
      if (v.fmt != cur_dxt5 || v.w != cur_width || v.h != cur_height) begin
        set_config(v.fmt, v.w, v.h);
      end
      blk = '{row: v.row, col: v.col, alpha: v.alpha, color: v.color};
      tpx = '{px_x: 14'd0, px_y: 14'd0, red: v.r, green: v.g, blue: v.b,
              alpha: v.a, last_px: 1'b1};
      send_block(blk, v.typed, v.typed_n, tpx);
    end

    // Random blocks in bursts, one settings phase after another
    burst_left = 0;
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: set_config(1'b0, MaxDim, MaxDim);
        1: set_config(1'b1, $urandom_range(1, 48), $urandom_range(1, 48));
        2: set_config(1'b0, $urandom_range(1, 48), $urandom_range(1, 48));
        3: set_config(1'b1, 1, 1);
        4: set_config(1'b1, $urandom_range(MaxDim, 32767), $urandom_range(1, 32767));
        default: set_config(1'b0, $urandom_range(1, 32767), $urandom_range(1, 48));
      endcase
      if (ph == 1) begin
        reg_write(REG_UNUSED, $urandom);
        check_regs();
      end
      wlim = ((cur_width > MaxDim) ? MaxDim : cur_width) / 4 + 1;
      hlim = ((cur_height > MaxDim) ? MaxDim : cur_height) / 4 + 1;
      if (wlim > 4095) wlim = 4095;
      if (hlim > 4095) hlim = 4095;
      for (i = 0; i < PhaseItems; i++) begin
        // Start a new burst, after a random gap or none
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 30)
                                                   : $urandom_range(1, 8);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          if (gap != 0) begin
            @(negedge clk_i);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk_i);
          end
        end
        burst_left--;
        blk.color = {$urandom, $urandom};
        blk.alpha = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0) blk.color[31:16] = blk.color[15:0];
        if ($urandom_range(0, 7) == 0) blk.alpha[15:8] = blk.alpha[7:0];
        blk.col = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, wlim));
        blk.row = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, hlim));
        send_block(blk, 1'b0, 1'b0, '0);
        // Long receiver hold while the sender keeps offering blocks
        if (ph == 0 && i == 2) hold_req = 1'b1;
        // Pause the sender until the output has caught up
        if (ph == 2 && i == 8) wait_drain();
      end
    end

    wait_drain();
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("[dxt_block_decompress] OK");
    end else begin
      $display("[dxt_block_decompress] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/dxt_pkg.sv
sv/dxt_cfg.sv
sv/dxt_palette.sv
sv/dxt_serial.sv
sv/dxt_block_decompress.sv
sv/dxt_chk.sv
bench/tb_top.sv
